[sv/cstr_pkg.sv]
// Shared types, register indexes and state codes for the command send/retry sequencer.
package cstr_pkg;

	// Register indexes on the configuration port (byte address is four times the index).
	localparam logic [2:0] REG_ENABLED        = 3'd0;
	localparam logic [2:0] REG_EXPECTS_REPLY  = 3'd1;
	localparam logic [2:0] REG_INITIAL_DELAY  = 3'd2;
	localparam logic [2:0] REG_PERIOD         = 3'd3;
	localparam logic [2:0] REG_TIMEOUT        = 3'd4;
	localparam logic [2:0] REG_RETRY_LIMIT    = 3'd5;
	localparam logic [2:0] REG_REPEAT_OPTIONS = 3'd6;

	// Reset value of the reply timeout.
	localparam logic [31:0] TIMEOUT_RESET = 32'd1000;

	// Bits of the repeat options register.
	localparam int unsigned OPT_ON_TIMEOUT = 0;
	localparam int unsigned OPT_ON_REPLY   = 1;
	localparam int unsigned OPT_FOREVER    = 2;

	// State codes as reported in the result item.
	localparam logic [2:0] CODE_IDLE    = 3'd0;
	localparam logic [2:0] CODE_SENT    = 3'd1;
	localparam logic [2:0] CODE_WAIT    = 3'd2;
	localparam logic [2:0] CODE_TIMEOUT = 3'd3;
	localparam logic [2:0] CODE_DONE    = 3'd4;

	// Command state machine, one-hot.
	typedef enum logic [4:0] {
		PH_IDLE    = 5'b00001,
		PH_SENT    = 5'b00010,
		PH_WAIT    = 5'b00100,
		PH_TIMEOUT = 5'b01000,
		PH_DONE    = 5'b10000
	} phase_t;

	// Maps the internal state to the reported state code.
	function automatic logic [2:0] phase_code(input phase_t ph);
		logic [2:0] code;
		case (ph)
			PH_IDLE:    code = CODE_IDLE;
			PH_SENT:    code = CODE_SENT;
			PH_WAIT:    code = CODE_WAIT;
			PH_TIMEOUT: code = CODE_TIMEOUT;
			PH_DONE:    code = CODE_DONE;
			default:    code = CODE_IDLE;
		endcase
		return code;
	endfunction

endpackage

[sv/command_send_timeout_retry_fsm_unit.sv]
// Top level of the command send, reply timeout and retry sequencer.

// One item is one poll tick: the current millisecond time and a reply-arrived
// flag. The block accepts one item per clock cycle and delivers its result in the next
// cycle from an output register; a tick is also taken while the waiting result leaves, so
// the sustained rate is one item per cycle whenever the output side takes results every
// cycle. The result holds the state after the tick and the send, reply and timeout pulses.
// All sequencer state updates at the edge that accepts the item, unless that edge writes
// the initial delay. Time differences wrap modulo 2^32. Configuration registers sit at
// byte addresses 0 to 24 and the user must write them only while the block is
// idle, which it does not enforce; writing the initial delay also reloads the running delay.
module command_send_timeout_retry_fsm_unit (
	input  logic        clk,
	input  logic        arst_n,
	// Input item stream.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // [31:0] now_ms, [32] reply_arrived, [39:33] zero
	// Result item stream.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // [2:0] cmd_state, [3] send_event, [4] reply_event,
	                                   // [5] timeout_event, [7:6] zero
	// Configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import cstr_pkg::*;

	// Configuration registers.
	logic        enabled_q;
	logic        expects_reply_q;
	logic [31:0] initial_delay_q;
	logic [31:0] period_q;
	logic [31:0] timeout_q;
	logic [7:0]  retry_limit_q;
	logic [2:0]  repeat_opt_q;

	// Sequencer state.
	phase_t      phase_q, phase_n;
	logic [31:0] delay_start_q, delay_start_n;
	logic [31:0] timeout_start_q, timeout_start_n;
	logic [31:0] running_delay_q, running_delay_n;
	logic [7:0]  retry_count_q, retry_count_n;
	logic        mark_q, mark_n;

	// Result register.
	logic        out_valid_q;
	logic [2:0]  out_state_q;
	logic        out_send_q, out_reply_q, out_timeout_q;

	logic        send_ev, reply_ev, timeout_ev;
	logic        in_accept;
	logic        cfg_write;
	logic [2:0]  cfg_index;
	logic [31:0] now;
	logic        reply_in;
	logic        mark_v;
	logic        done_release;
	logic [31:0] elapsed;
	logic [31:0] late;
	logic [31:0] wait_elapsed;

	assign now       = s_axis_tdata[31:0];
	assign reply_in  = s_axis_tdata[32];
	assign in_accept = s_axis_tvalid && s_axis_tready;

	// The result register frees up when it is empty or being taken.
	assign s_axis_tready = !out_valid_q || m_axis_tready;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign cfg_index = paddr[4:2];

	// Register read-back.
	always_comb begin
		case (cfg_index)
			REG_ENABLED:        prdata = {31'd0, enabled_q};
			REG_EXPECTS_REPLY:  prdata = {31'd0, expects_reply_q};
			REG_INITIAL_DELAY:  prdata = initial_delay_q;
			REG_PERIOD:         prdata = period_q;
			REG_TIMEOUT:        prdata = timeout_q;
			REG_RETRY_LIMIT:    prdata = {24'd0, retry_limit_q};
			REG_REPEAT_OPTIONS: prdata = {29'd0, repeat_opt_q};
			default:            prdata = 32'd0;
		endcase
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q       <= 1'b0;
			expects_reply_q <= 1'b0;
			initial_delay_q <= 32'd0;
			period_q        <= 32'd0;
			timeout_q       <= TIMEOUT_RESET;
			retry_limit_q   <= 8'd0;
			repeat_opt_q    <= 3'd0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_ENABLED:        enabled_q       <= pwdata[0];
				REG_EXPECTS_REPLY:  expects_reply_q <= pwdata[0];
				REG_INITIAL_DELAY:  initial_delay_q <= pwdata;
				REG_PERIOD:         period_q        <= pwdata;
				REG_TIMEOUT:        timeout_q       <= pwdata;
				REG_RETRY_LIMIT:    retry_limit_q   <= pwdata[7:0];
				REG_REPEAT_OPTIONS: repeat_opt_q    <= pwdata[2:0];
				default: ;
			endcase
		end
	end

	// Time differences for the send delay and the reply timeout.
	assign elapsed      = now - delay_start_q;
	assign late         = elapsed - running_delay_q;
	assign wait_elapsed = now - timeout_start_q;

	// The replied mark includes this tick's reply flag.
	assign mark_v = mark_q || reply_in;

	// Done releases back to idle when periodic, repeating on reply once a reply is marked, or forever.
	assign done_release = (period_q != 32'd0) ||
		(mark_v && repeat_opt_q[OPT_ON_REPLY]) || repeat_opt_q[OPT_FOREVER];

	// Next state for one tick.
	always_comb begin
		phase_n         = phase_q;
		delay_start_n   = delay_start_q;
		timeout_start_n = timeout_start_q;
		running_delay_n = running_delay_q;
		retry_count_n   = retry_count_q;
		mark_n          = mark_q;
		send_ev         = 1'b0;
		reply_ev        = 1'b0;
		timeout_ev      = 1'b0;
		if (enabled_q) begin
			mark_n = mark_v;
			case (phase_q)
				PH_IDLE: begin
					if (elapsed >= running_delay_q) begin
						if (period_q != 32'd0) begin
							running_delay_n = (period_q > late) ? (period_q - late) : 32'd0;
						end
						delay_start_n   = now;
						timeout_start_n = now;
						send_ev         = 1'b1;
						phase_n         = expects_reply_q ? PH_SENT : PH_DONE;
					end
				end
				PH_SENT, PH_WAIT: begin
					phase_n = PH_WAIT;
					if (mark_v) begin
						reply_ev = 1'b1;
						phase_n  = PH_DONE;
					end else if (wait_elapsed >= timeout_q) begin
						timeout_ev = 1'b1;
						phase_n    = PH_TIMEOUT;
					end
				end
				PH_TIMEOUT: begin
					if (repeat_opt_q[OPT_ON_TIMEOUT]) begin
						phase_n = PH_IDLE;
					end else if (retry_count_q < retry_limit_q) begin
						retry_count_n = retry_count_q + 8'd1;
						phase_n       = PH_IDLE;
					end
					// The done release check follows on the same tick.
					if (done_release) begin
						mark_n  = 1'b0;
						phase_n = PH_IDLE;
					end
				end
				PH_DONE: begin
					if (done_release) begin
						mark_n  = 1'b0;
						phase_n = PH_IDLE;
					end
				end
				default: ;
			endcase
		end
	end

	// Sequencer state registers; a write of the initial delay reloads the running delay.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_IDLE;
			delay_start_q   <= 32'd0;
			timeout_start_q <= 32'd0;
			running_delay_q <= 32'd0;
			retry_count_q   <= 8'd0;
			mark_q          <= 1'b0;
		end else if (cfg_write && (cfg_index == REG_INITIAL_DELAY)) begin
			running_delay_q <= pwdata;
		end else if (in_accept) begin
			phase_q         <= phase_n;
			delay_start_q   <= delay_start_n;
			timeout_start_q <= timeout_start_n;
			running_delay_q <= running_delay_n;
			retry_count_q   <= retry_count_n;
			mark_q          <= mark_n;
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_accept) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			out_state_q   <= phase_code(phase_n);
			out_send_q    <= send_ev;
			out_reply_q   <= reply_ev;
			out_timeout_q <= timeout_ev;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, out_timeout_q, out_reply_q, out_send_q, out_state_q};

`ifndef SYNTH
	// At most one event pulse per result item.
	a_one_event: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> $onehot0({out_send_q, out_reply_q, out_timeout_q}))
		else $error("more than one event pulse in a result item");

	// A send leaves the block in the sent or done state.
	a_send_state: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && out_send_q) |->
			(out_state_q == CODE_SENT || out_state_q == CODE_DONE))
		else $error("send event with an unexpected state");

	// A timeout pulse reports the timeout state.
	a_timeout_state: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && out_timeout_q) |-> (out_state_q == CODE_TIMEOUT))
		else $error("timeout event without the timeout state");

	// An accepted item always produces a result in the next cycle.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> m_axis_tvalid)
		else $error("accepted item produced no result");
`endif

endmodule

[bench/command_sequencer_checker.sv]
// Checker for the command sequencer: watches all channels, predicts each result and compares.
module command_sequencer_checker
	import cstr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // [31:0] now_ms, [32] reply_arrived, [39:33] zero
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [7:0]  m_axis_tdata,  // [2:0] cmd_state, [3] send_event, [4] reply_event,
	                                   // [5] timeout_event, [7:6] zero
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	// One result item as it appears on the result stream.
	typedef struct packed {
		logic [1:0] pad;
		logic       timeout_event;
		logic       reply_event;
		logic       send_event;
		logic [2:0] cmd_state;
	} tick_result_t;

	// Copy of the configuration registers.
	logic        en;
	logic        want_reply;
	logic [31:0] period;
	logic [31:0] timeout;
	logic [7:0]  retry_max;
	logic [2:0]  repeat_opts;

	// Copy of the sequencer state.
	logic [2:0]  seq_phase;
	logic [31:0] delay_origin;
	logic [31:0] reply_origin;
	logic [31:0] wait_delay;
	logic [7:0]  retries;
	logic        reply_seen;

	tick_result_t expected_ticks[$];
	tick_result_t want;
	tick_result_t seen;
	int           mismatches = 0;

	initial begin
		fail_count = 0;
		pending = 0;
	end

	// Return to idle from done when a repeat condition holds.
	task automatic leave_done();
		if (period != 32'd0 || (reply_seen && repeat_opts[OPT_ON_REPLY]) ||
		    repeat_opts[OPT_FOREVER]) begin
			reply_seen = 1'b0;
			seq_phase = CODE_IDLE;
		end
	endtask

	// Advance the predicted state by one poll tick and give the result it reports.
	task automatic predict_poll_tick(input logic [31:0] now, input logic reply,
	                                 output tick_result_t res);
		logic [31:0] elapsed;
		logic [31:0] late;
		res = '0;
		if (en) begin
			if (reply)
				reply_seen = 1'b1;
			case (seq_phase)
				CODE_IDLE: begin
					elapsed = now - delay_origin;
					if (elapsed >= wait_delay) begin
						// A periodic repeat shortens the next delay by the lateness of this send.
						if (period != 32'd0) begin
							late = elapsed - wait_delay;
							wait_delay = (period > late) ? period - late : 32'd0;
						end
						delay_origin = now;
						reply_origin = now;
						res.send_event = 1'b1;
						seq_phase = want_reply ? CODE_SENT : CODE_DONE;
					end
				end
				CODE_SENT, CODE_WAIT: begin
					seq_phase = CODE_WAIT;
					elapsed = now - reply_origin;
					if (reply_seen) begin
						res.reply_event = 1'b1;
						seq_phase = CODE_DONE;
					end else if (elapsed >= timeout) begin
						res.timeout_event = 1'b1;
						seq_phase = CODE_TIMEOUT;
					end
				end
				CODE_TIMEOUT: begin
					// Retries saturate at the limit and are never cleared.
					if (repeat_opts[OPT_ON_TIMEOUT]) begin
						seq_phase = CODE_IDLE;
					end else if (retries < retry_max) begin
						retries = retries + 8'd1;
						seq_phase = CODE_IDLE;
					end
					leave_done();
				end
				CODE_DONE: begin
					leave_done();
				end
				default: begin
				end
			endcase
		end
		res.cmd_state = seq_phase;
	endtask

	// Configuration writes first, then the result check, then the new prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en = 1'b0;
			want_reply = 1'b0;
			period = 32'd0;
			timeout = TIMEOUT_RESET;
			retry_max = 8'd0;
			repeat_opts = 3'd0;
			seq_phase = CODE_IDLE;
			delay_origin = 32'd0;
			reply_origin = 32'd0;
			wait_delay = 32'd0;
			retries = 8'd0;
			reply_seen = 1'b0;
			expected_ticks.delete();
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					REG_ENABLED:        en = pwdata[0];
					REG_EXPECTS_REPLY:  want_reply = pwdata[0];
					REG_INITIAL_DELAY:  wait_delay = pwdata;
					REG_PERIOD:         period = pwdata;
					REG_TIMEOUT:        timeout = pwdata;
					REG_RETRY_LIMIT:    retry_max = pwdata[7:0];
					REG_REPEAT_OPTIONS: repeat_opts = pwdata[2:0];
					default: begin
					end
				endcase
			end

			if (m_axis_tvalid && m_axis_tready) begin
				seen = m_axis_tdata;
				if (expected_ticks.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result item: state %0d send %0b reply %0b timeout %0b",
						         seen.cmd_state, seen.send_event, seen.reply_event,
						         seen.timeout_event);
				end else begin
					want = expected_ticks.pop_front();
					if (seen.cmd_state != want.cmd_state || seen.send_event != want.send_event ||
					    seen.reply_event != want.reply_event ||
					    seen.timeout_event != want.timeout_event) begin
						mismatches++;
						if (mismatches <= 10)
							$display("result mismatch: expected state %0d send %0b reply %0b %s %0b",
							         want.cmd_state, want.send_event, want.reply_event,
							         "timeout", want.timeout_event,
							         ", got state %0d send %0b reply %0b timeout %0b",
							         seen.cmd_state, seen.send_event, seen.reply_event,
							         seen.timeout_event);
					end
				end
			end

			if (s_axis_tvalid && s_axis_tready) begin
				predict_poll_tick(s_axis_tdata[31:0], s_axis_tdata[32], want);
				expected_ticks.push_back(want);
			end

			pending <= expected_ticks.size();
		end
		fail_count <= mismatches;
	end

endmodule

[bench/command_send_timeout_retry_fsm_unit_test.sv]
// Testbench top for the command sequencer: clock, reset, stimulus, handshake pressure and verdict.
module command_send_timeout_retry_fsm_unit_test;
	import cstr_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;  // [31:0] now_ms, [32] reply_arrived, [39:33] zero
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b1;
	logic [7:0]  m_axis_tdata;       // [2:0] cmd_state, [3] send_event, [4] reply_event,
	                                 // [5] timeout_event, [7:6] zero
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	int          fail_count;
	int          pending;
	int          sender_idle_pct = 0;
	int          receiver_stall_pct = 0;
	int          cycles = 0;
	logic [31:0] clock_ms = 32'd0;

	command_send_timeout_retry_fsm_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	command_sequencer_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.pready       (pready),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	always #5 clk = ~clk;

	// Result side stalls at random for the current share of cycles.
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99, 0) >= receiver_stall_pct);
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Register write: stop offering items and let the last result leave, then a setup
	// phase and an access phase.
	task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (m_axis_tvalid) @(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Offer one poll tick, after a random idle stretch, and wait until it is taken.
	task automatic poll(input logic [31:0] now, input logic reply);
		if ($urandom_range(99, 0) < sender_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99, 0) < sender_idle_pct) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {7'd0, reply, now};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	// Stop sending and wait until every predicted result has arrived.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		repeat (2) @(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// Mostly short times, sometimes an extreme or a fully random one.
	function automatic logic [31:0] pick_ms(input int small_max);
		int r;
		r = $urandom_range(99, 0);
		if (r < 5)
			return 32'd0;
		else if (r < 10)
			return 32'hFFFF_FFFF;
		else if (r < 13)
			return $urandom;
		return $urandom_range(small_max, 0);
	endfunction

	// New settings for a random phase; every register is written.
	task automatic pick_settings();
		int r;
		reg_write(REG_ENABLED, ($urandom_range(99, 0) < 90) ? 32'd1 : 32'd0);
		reg_write(REG_EXPECTS_REPLY, ($urandom_range(99, 0) < 75) ? 32'd1 : 32'd0);
		reg_write(REG_INITIAL_DELAY, pick_ms(15));
		reg_write(REG_PERIOD, ($urandom_range(99, 0) < 40) ? 32'd0 : pick_ms(20));
		reg_write(REG_TIMEOUT, pick_ms(12));
		r = $urandom_range(99, 0);
		reg_write(REG_RETRY_LIMIT, (r < 80) ? $urandom_range(3, 0) :
		                           (r < 90) ? 32'd255 : $urandom_range(255, 0));
		reg_write(REG_REPEAT_OPTIONS, $urandom_range(7, 0));
	endtask

	// Random ticks on a mostly steady clock, with jumps and stray times mixed in.
	task automatic random_ticks(input int count, input int reply_pct);
		int r;
		logic [31:0] now;
		for (int k = 0; k < count; k++) begin
			r = $urandom_range(99, 0);
			if (r < 80) begin
				clock_ms = clock_ms + $urandom_range(3, 0);
				now = clock_ms;
			end else if (r < 92) begin
				clock_ms = clock_ms + $urandom_range(40, 0);
				now = clock_ms;
			end else if (r < 96) begin
				clock_ms = $urandom;
				now = clock_ms;
			end else begin
				now = $urandom;
			end
			poll(now, $urandom_range(99, 0) < reply_pct);
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Disabled after reset: ticks change nothing, a reply is not remembered.
		poll(32'hFFFF_FFFF, 1'b1);
		poll(32'd0, 1'b0);
		poll(32'd3, 1'b1);

		// Reply expected, short delay and timeout, one retry allowed.
		reg_write(REG_ENABLED, 32'd1);
		reg_write(REG_EXPECTS_REPLY, 32'd1);
		reg_write(REG_INITIAL_DELAY, 32'd5);
		reg_write(REG_PERIOD, 32'd0);
		reg_write(REG_TIMEOUT, 32'd3);
		reg_write(REG_RETRY_LIMIT, 32'd1);
		reg_write(REG_REPEAT_OPTIONS, 32'd0);
		// Waiting out the delay, send, timeout, then a retry.
		poll(32'd2, 1'b0);
		poll(32'd5, 1'b0);
		poll(32'd6, 1'b0);
		poll(32'd8, 1'b0);
		poll(32'd9, 1'b0);
		// Second send answered by a reply; done holds without repeat options.
		poll(32'd14, 1'b0);
		poll(32'd15, 1'b1);
		poll(32'd16, 1'b0);
		// Third round times out with the retries used up; the forever option still returns it to idle.
		drain();
		reg_write(REG_REPEAT_OPTIONS, 32'd4);
		poll(32'd17, 1'b0);
		poll(32'd30, 1'b0);
		poll(32'd31, 1'b0);
		poll(32'd40, 1'b0);
		poll(32'd41, 1'b0);
		drain();

		// Extremes: largest period and zero timeout, time wrapping past the top.
		reg_write(REG_REPEAT_OPTIONS, 32'd7);
		reg_write(REG_PERIOD, 32'hFFFF_FFFF);
		reg_write(REG_TIMEOUT, 32'd0);
		reg_write(REG_RETRY_LIMIT, 32'd255);
		poll(32'd42, 1'b0);
		poll(32'hFFFF_FFFE, 1'b0);
		poll(32'hFFFF_FFFF, 1'b0);
		poll(32'd1, 1'b0);
		poll(32'd2, 1'b1);
		drain();

		// Largest initial delay reloads the running delay; none of these ticks reaches it, so none sends.
		reg_write(REG_INITIAL_DELAY, 32'hFFFF_FFFF);
		reg_write(REG_TIMEOUT, 32'hFFFF_FFFF);
		reg_write(REG_EXPECTS_REPLY, 32'd0);
		reg_write(REG_PERIOD, 32'd0);
		poll(32'd100, 1'b0);
		poll(32'h0000_0000, 1'b0);
		poll(32'hFFFF_FFFF, 1'b1);
		drain();

		// Random phases, cycling through the idling modes.
		clock_ms = 32'd1000;
		for (int ph = 0; ph < 12; ph++) begin
			case (ph % 4)
				0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
				1: begin sender_idle_pct = 56; receiver_stall_pct = 0;  end
				2: begin sender_idle_pct = 0;  receiver_stall_pct = 56; end
				default: begin sender_idle_pct = 10; receiver_stall_pct = 10; end
			endcase
			if (ph == 5)
				clock_ms = 32'hFFFF_FFE0;
			pick_settings();
			random_ticks(42, $urandom_range(40, 5));
			drain();
		end

		if (fail_count == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

[sim.f]
sv/cstr_pkg.sv
sv/command_send_timeout_retry_fsm_unit.sv
bench/command_sequencer_checker.sv
bench/command_send_timeout_retry_fsm_unit_test.sv
